// ===== rtl/i2cseq_pkg.sv =====
// Shared types, codes and step program tables for the I2C transaction sequencer.
package i2cseq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int TX_FIFO_DEPTH_DEF = 16;
  localparam int OUT_DEPTH         = 4;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_EVENT   = 2'd2;

  localparam logic [2:0] KIND_QUICK_RD = 3'd0;
  localparam logic [2:0] KIND_QUICK_WR = 3'd1;
  localparam logic [2:0] KIND_SEND     = 3'd2;
  localparam logic [2:0] KIND_RECV     = 3'd3;
  localparam logic [2:0] KIND_WR_RD    = 3'd4;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_START    = 3'd1;
  localparam logic [2:0] ERR_ADDR     = 3'd2;
  localparam logic [2:0] ERR_WRITE    = 3'd3;
  localparam logic [2:0] ERR_PROTOCOL = 3'd4;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_AW_ACK    = 8'h18;
  localparam logic [7:0] ST_AW_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_AR_ACK    = 8'h40;
  localparam logic [7:0] ST_AR_NACK   = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_ADDR_RD  = 3'd2,
    CMD_ADDR_WR  = 3'd3,
    CMD_DATA     = 3'd4,
    CMD_READ_ACK = 3'd5,
    CMD_READ_NAK = 3'd6,
    CMD_STOP     = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    P_START      = 4'd0,
    P_RESTART    = 4'd1,
    P_START_DONE = 4'd2,
    P_ADDR_R     = 4'd3,
    P_ADDR_W     = 4'd4,
    P_ADDR_ACK   = 4'd5,
    P_SEND       = 4'd6,
    P_SEND_ACK   = 4'd7,
    P_RECV_READY = 4'd8,
    P_RECV_LOOP  = 4'd9,
    P_STOP       = 4'd10
  } step_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] txn_kind;
    logic [6:0] target_address;
    logic [7:0] send_count;
    logic [7:0] recv_count;
    logic [7:0] tx_byte;
    logic [7:0] status_code;
    logic [7:0] rx_data;
  } req_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] command_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [2:0] done_status;
    logic       rejected;
    logic       fault;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] addr;
    logic [7:0] send;
    logic [7:0] recv;
  } entry_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       item0;
    res_t       item1;
  } push_t;

  function automatic step_t prog_code(logic [2:0] kind, logic [3:0] idx);
    step_t c;
    c = P_STOP;
    unique case (kind)
      KIND_QUICK_RD, KIND_QUICK_WR, KIND_SEND, KIND_RECV: begin
        unique case (idx)
          4'd0: c = P_START;
          4'd1: c = P_START_DONE;
          4'd2: c = (kind == KIND_QUICK_RD || kind == KIND_RECV) ? P_ADDR_R : P_ADDR_W;
          4'd3: c = P_ADDR_ACK;
          4'd4: c = (kind == KIND_SEND) ? P_SEND :
                    (kind == KIND_RECV) ? P_RECV_READY : P_STOP;
          4'd5: c = (kind == KIND_SEND) ? P_SEND_ACK :
                    (kind == KIND_RECV) ? P_RECV_LOOP : P_STOP;
          default: c = P_STOP;
        endcase
      end
      KIND_WR_RD: begin
        unique case (idx)
          4'd0:  c = P_START;
          4'd1:  c = P_START_DONE;
          4'd2:  c = P_ADDR_W;
          4'd3:  c = P_ADDR_ACK;
          4'd4:  c = P_SEND;
          4'd5:  c = P_SEND_ACK;
          4'd6:  c = P_RESTART;
          4'd7:  c = P_START_DONE;
          4'd8:  c = P_ADDR_R;
          4'd9:  c = P_ADDR_ACK;
          4'd10: c = P_RECV_READY;
          4'd11: c = P_RECV_LOOP;
          default: c = P_STOP;
        endcase
      end
      default: c = P_STOP;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] stop_index(logic [2:0] kind);
    logic [3:0] s;
    unique case (kind)
      KIND_QUICK_RD, KIND_QUICK_WR: s = 4'd4;
      KIND_SEND, KIND_RECV:         s = 4'd6;
      KIND_WR_RD:                   s = 4'd12;
      default:                      s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/i2cseq_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface i2cseq_req_if;
  logic                valid;
  logic                ready;
  i2cseq_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cseq_res_if;
  logic                valid;
  logic                ready;
  i2cseq_pkg::res_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master transaction sequencer.
// The req channel carries one item per request, transmit byte load or bus
// status event; mode selects which. Requests start at once when idle and
// otherwise wait in the request queue; transmit bytes wait in the send FIFO.
// Each status event steps the active transaction and gives one result item
// on the res channel, or two when a stop is followed by the start of the
// next queued request; the last flag marks the final item of each input.
// An input item is registered, evaluated combinationally, and its results
// are written to a four-entry result buffer that feeds the res channel.
// One input item is taken per cycle while the result buffer has room for
// two more items; the rate is set by the res side, one result item per
// cycle. When res stalls, the buffer fills and req.ready drops once it holds
// three items, after at most four further input items. Reset empties the
// queue, the send FIFO and the result buffer and leaves the sequencer idle;
// no clearing pass is needed.
module i2c_master_transaction_sequencer #(
  parameter int QUEUE_DEPTH   = i2cseq_pkg::QUEUE_DEPTH_DEF,
  parameter int TX_FIFO_DEPTH = i2cseq_pkg::TX_FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  i2cseq_req_if.sink    req,
  i2cseq_res_if.source  res
);

  i2cseq_pkg::push_t push;
  logic              room;

  i2cseq_engine #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TX_FIFO_DEPTH (TX_FIFO_DEPTH)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .room (room),
    .push (push)
  );

  i2cseq_out_fifo u_out (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

// ===== rtl/i2cseq_engine.sv =====
// Input reg, request queue, send FIFO, step program; one item per cycle with room.
module i2cseq_engine #(
  parameter int QUEUE_DEPTH   = i2cseq_pkg::QUEUE_DEPTH_DEF,
  parameter int TX_FIFO_DEPTH = i2cseq_pkg::TX_FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  i2cseq_req_if.sink         req,
  input  logic               room,
  output i2cseq_pkg::push_t  push
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int FPW = (TX_FIFO_DEPTH > 1) ? $clog2(TX_FIFO_DEPTH) : 1;
  localparam int FCW = $clog2(TX_FIFO_DEPTH + 1);

  i2cseq_pkg::req_t   in_q;
  logic               in_vld;
  logic               fire;

  logic               busy, busy_next;
  logic [3:0]         step, step_next;
  logic [2:0]         kind, kind_next;
  logic [6:0]         addr, addr_next;
  logic [7:0]         send, send_next;
  logic [7:0]         recv, recv_next;
  logic [7:0]         bidx, bidx_next;
  logic [2:0]         err, err_next;

  i2cseq_pkg::entry_t queue [QUEUE_DEPTH];
  logic [QPW-1:0]     qhead, qtail;
  logic [QCW-1:0]     qcount, qcount_next;
  logic               qpush, qpop;
  i2cseq_pkg::entry_t qentry;

  logic [7:0]         fifo [TX_FIFO_DEPTH];
  logic [FPW-1:0]     fhead, ftail;
  logic [FCW-1:0]     fcount, fcount_next;
  logic               fpush, fpop;

  assign fire      = in_vld && room;
  assign req.ready = !in_vld || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
    if (req.ready && req.valid) begin
      in_q <= req.payload;
    end
  end

  always_comb begin
    i2cseq_pkg::res_t   it0, it1;
    i2cseq_pkg::step_t  code0, code1;
    logic [1:0]         n;
    logic [7:0]         st;
    logic [3:0]         s1;
    logic [7:0]         b1;
    logic [2:0]         e1;
    logic               bad;
    logic [7:0]         sc, rc;
    it0 = '0;
    it1 = '0;
    n = 2'd0;
    busy_next = busy;
    step_next = step;
    kind_next = kind;
    addr_next = addr;
    send_next = send;
    recv_next = recv;
    bidx_next = bidx;
    err_next = err;
    qpush = 1'b0;
    qpop = 1'b0;
    qentry = '0;
    fpush = 1'b0;
    fpop = 1'b0;
    st = in_q.status_code & 8'hF8;
    s1 = step;
    b1 = bidx;
    e1 = err;
    sc = in_q.send_count;
    rc = in_q.recv_count;
    code0 = i2cseq_pkg::prog_code(kind, step);
    code1 = code0;
    bad = 1'b0;
    if (fire) begin
      case (in_q.mode)
        i2cseq_pkg::MODE_REQUEST: begin
          n = 2'd1;
          bad = (in_q.txn_kind > i2cseq_pkg::KIND_WR_RD)
              || ((in_q.txn_kind == i2cseq_pkg::KIND_SEND
                   || in_q.txn_kind == i2cseq_pkg::KIND_WR_RD) && sc == 8'd0)
              || (in_q.txn_kind == i2cseq_pkg::KIND_WR_RD && rc == 8'd0)
              || (busy && qcount >= QCW'(QUEUE_DEPTH));
          if (in_q.txn_kind <= i2cseq_pkg::KIND_QUICK_WR) begin
            sc = 8'd0;
            rc = 8'd0;
          end else if (in_q.txn_kind == i2cseq_pkg::KIND_SEND) begin
            rc = 8'd0;
          end else if (in_q.txn_kind == i2cseq_pkg::KIND_RECV) begin
            sc = 8'd0;
            rc = 8'd1;
          end
          qentry = '{kind: in_q.txn_kind, addr: in_q.target_address, send: sc, recv: rc};
          if (bad) begin
            it0.rejected = 1'b1;
          end else if (!busy) begin
            kind_next = in_q.txn_kind;
            addr_next = in_q.target_address;
            send_next = sc;
            recv_next = rc;
            bidx_next = 8'd0;
            err_next = i2cseq_pkg::ERR_NONE;
            step_next = 4'd1;
            busy_next = 1'b1;
            it0.bus_command = i2cseq_pkg::CMD_START;
          end else begin
            qpush = 1'b1;
          end
        end
        i2cseq_pkg::MODE_LOAD: begin
          n = 2'd1;
          if (fcount < FCW'(TX_FIFO_DEPTH)) begin
            fpush = 1'b1;
          end else begin
            it0.rejected = 1'b1;
          end
        end
        i2cseq_pkg::MODE_EVENT: begin
          n = 2'd1;
          if (!busy) begin
            it0.fault = 1'b1;
          end else begin
            case (code0)
              i2cseq_pkg::P_START_DONE: begin
                if (st == i2cseq_pkg::ST_START || st == i2cseq_pkg::ST_RESTART) begin
                  s1 = step + 4'd1;
                end else begin
                  e1 = i2cseq_pkg::ERR_START;
                  s1 = i2cseq_pkg::stop_index(kind);
                end
              end
              i2cseq_pkg::P_ADDR_ACK: begin
                if (st == i2cseq_pkg::ST_AW_ACK || st == i2cseq_pkg::ST_AR_ACK) begin
                  s1 = step + 4'd1;
                end else begin
                  e1 = (st == i2cseq_pkg::ST_AW_NACK || st == i2cseq_pkg::ST_AR_NACK) ?
                       i2cseq_pkg::ERR_ADDR : i2cseq_pkg::ERR_PROTOCOL;
                  s1 = i2cseq_pkg::stop_index(kind);
                end
              end
              i2cseq_pkg::P_SEND_ACK: begin
                if (st == i2cseq_pkg::ST_DATA_ACK) begin
                  s1 = (bidx < send) ? step - 4'd1 : step + 4'd1;
                end else begin
                  e1 = (st == i2cseq_pkg::ST_DATA_NACK) ?
                       i2cseq_pkg::ERR_WRITE : i2cseq_pkg::ERR_PROTOCOL;
                  s1 = i2cseq_pkg::stop_index(kind);
                end
              end
              i2cseq_pkg::P_RECV_LOOP: begin
                if (bidx < recv) begin
                  it0.rx_valid = 1'b1;
                  it0.rx_byte = in_q.rx_data;
                  b1 = bidx + 8'd1;
                end else begin
                  it0.fault = 1'b1;
                end
                if (st == i2cseq_pkg::ST_RX_ACK) begin
                  s1 = step - 4'd1;
                end else if (st == i2cseq_pkg::ST_RX_NACK) begin
                  s1 = step + 4'd1;
                end else begin
                  e1 = i2cseq_pkg::ERR_PROTOCOL;
                  s1 = i2cseq_pkg::stop_index(kind);
                end
              end
              default: ;
            endcase
            code1 = i2cseq_pkg::prog_code(kind, s1);
            step_next = s1;
            bidx_next = b1;
            err_next = e1;
            case (code1)
              i2cseq_pkg::P_START, i2cseq_pkg::P_RESTART: begin
                bidx_next = 8'd0;
                step_next = s1 + 4'd1;
                it0.bus_command = i2cseq_pkg::CMD_START;
              end
              i2cseq_pkg::P_ADDR_R: begin
                it0.bus_command = i2cseq_pkg::CMD_ADDR_RD;
                it0.command_byte = {addr, 1'b1};
                step_next = s1 + 4'd1;
              end
              i2cseq_pkg::P_ADDR_W: begin
                it0.bus_command = i2cseq_pkg::CMD_ADDR_WR;
                it0.command_byte = {addr, 1'b0};
                step_next = s1 + 4'd1;
              end
              i2cseq_pkg::P_SEND: begin
                if (fcount != '0) begin
                  fpop = 1'b1;
                  it0.command_byte = fifo[fhead];
                end else begin
                  it0.fault = 1'b1;
                end
                bidx_next = b1 + 8'd1;
                it0.bus_command = i2cseq_pkg::CMD_DATA;
                step_next = s1 + 4'd1;
              end
              i2cseq_pkg::P_RECV_READY: begin
                it0.bus_command = (({1'b0, b1} + 9'd1) < {1'b0, recv}) ?
                                  i2cseq_pkg::CMD_READ_ACK : i2cseq_pkg::CMD_READ_NAK;
                step_next = s1 + 4'd1;
              end
              i2cseq_pkg::P_STOP: begin
                it0.bus_command = i2cseq_pkg::CMD_STOP;
                it0.done_res = 1'b1;
                it0.done_status = e1;
                busy_next = 1'b0;
                step_next = 4'd0;
                if (qcount != '0) begin
                  qpop = 1'b1;
                  n = 2'd2;
                  kind_next = queue[qhead].kind;
                  addr_next = queue[qhead].addr;
                  send_next = queue[qhead].send;
                  recv_next = queue[qhead].recv;
                  bidx_next = 8'd0;
                  err_next = i2cseq_pkg::ERR_NONE;
                  step_next = 4'd1;
                  busy_next = 1'b1;
                  it1.bus_command = i2cseq_pkg::CMD_START;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    it0.last = (n != 2'd2);
    it1.last = 1'b1;
    push.count = n;
    push.item0 = it0;
    push.item1 = it1;
  end

  always_comb begin
    qcount_next = qcount;
    if (qpush) qcount_next = qcount + QCW'(1);
    else if (qpop) qcount_next = qcount - QCW'(1);
    fcount_next = fcount;
    if (fpush) fcount_next = fcount + FCW'(1);
    else if (fpop) fcount_next = fcount - FCW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
      kind <= 3'd0;
      addr <= 7'd0;
      send <= 8'd0;
      recv <= 8'd0;
      bidx <= 8'd0;
      err <= 3'd0;
      qhead <= '0;
      qtail <= '0;
      qcount <= '0;
      fhead <= '0;
      ftail <= '0;
      fcount <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
      kind <= kind_next;
      addr <= addr_next;
      send <= send_next;
      recv <= recv_next;
      bidx <= bidx_next;
      err <= err_next;
      qcount <= qcount_next;
      fcount <= fcount_next;
      if (qpush) qtail <= (qtail == QPW'(QUEUE_DEPTH - 1)) ? '0 : qtail + QPW'(1);
      if (qpop) qhead <= (qhead == QPW'(QUEUE_DEPTH - 1)) ? '0 : qhead + QPW'(1);
      if (fpush) ftail <= (ftail == FPW'(TX_FIFO_DEPTH - 1)) ? '0 : ftail + FPW'(1);
      if (fpop) fhead <= (fhead == FPW'(TX_FIFO_DEPTH - 1)) ? '0 : fhead + FPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (qpush) queue[qtail] <= qentry;
    if (fpush) fifo[ftail] <= in_q.tx_byte;
  end

endmodule

// ===== rtl/i2cseq_out_fifo.sv =====
// Result buffer that takes up to two items per cycle and hands out one.
module i2cseq_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  i2cseq_pkg::push_t  push,
  output logic               room,
  i2cseq_res_if.source       res
);

  localparam int PW = $clog2(i2cseq_pkg::OUT_DEPTH);
  localparam int CW = $clog2(i2cseq_pkg::OUT_DEPTH + 1);

  i2cseq_pkg::res_t mem [i2cseq_pkg::OUT_DEPTH];
  logic [PW-1:0]    head, tail;
  logic [CW-1:0]    count, count_next;
  logic             pop;

  assign pop         = res.valid && res.ready;
  assign res.valid   = (count != '0);
  assign res.payload = mem[head];
  assign room        = (count <= CW'(i2cseq_pkg::OUT_DEPTH - 2));

  always_comb begin
    count_next = count + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      tail <= tail + PW'(push.count);
      if (pop) head <= head + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[tail] <= push.item0;
    if (push.count == 2'd2) mem[tail + PW'(1)] <= push.item1;
  end

endmodule
